>>> sv/http_chunked_body_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define HCBD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked during reset as well
`define HCBD_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCBD_ASSERT(label, clk, rst, prop, msg)
`define HCBD_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

>>> sv/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, codes and character helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int SIZE_BITS_DEFAULT = 32;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_OVF   = 3'd4;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [6:0] {
    PH_WS   = 7'b0000001,
    PH_ZERO = 7'b0000010,
    PH_HEX  = 7'b0000100,
    PH_TAIL = 7'b0001000,
    PH_DATA = 7'b0010000,
    PH_SKIP = 7'b0100000,
    PH_STOP = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

>>> sv/hcbd_if.sv
// ----------------------------------------------------------------------------
// hcbd channel interfaces
// Valid/ready channels for raw body bytes and for decoded result words.
// ----------------------------------------------------------------------------
interface hcbd_body_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       is_last;

  modport source (output valid, output body_byte, output is_last, input ready);
  modport sink   (input valid, input body_byte, input is_last, output ready);
endinterface

interface hcbd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] status;

  modport source (output valid, output out_byte, output byte_valid, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input status,
                  output ready);
endinterface

>>> sv/http_chunked_body_decoder.sv
// Each accepted body word yields one result word, registered in the output register.
// Throughput: one word per cycle unless the result side stalls; state updates on acceptance.
// The output register refills in the cycle it is taken, so a stall on the result side alone
// holds the input off.
// Reset (rst, synchronous): decoder back to the size line with no digits, output register empty.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 chunked transfer decoder: one body byte in, one result word out.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_assert.svh"

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  hcbd_body_if.sink   body,
  hcbd_result_if.source result
);

  hcbd_pkg::phase_t       phase, phase_next;
  logic [SIZE_BITS-1:0]   size_accum, size_accum_next;
  logic [SIZE_BITS-1:0]   bytes_left, bytes_left_next;
  logic                   digit_seen, digit_seen_next;
  logic [1:0]             skip_left, skip_left_next;
  logic                   line_cr, line_cr_next;
  logic [2:0]             final_st, final_st_next;

  logic                   out_valid;
  logic [7:0]             out_byte;
  logic                   byte_valid;
  logic [2:0]             status;

  logic                   accept;
  logic                   emit;
  hcbd_pkg::hex_digit_t   dig;
  logic [7:0]             c;

  assign body.ready = !out_valid || result.ready;
  assign accept     = body.valid && body.ready;
  assign c          = body.body_byte;
  assign dig        = hcbd_pkg::hex_value(c);

  always_comb begin
    logic done;
    phase_next      = phase;
    size_accum_next = size_accum;
    bytes_left_next = bytes_left;
    digit_seen_next = digit_seen;
    skip_left_next  = skip_left;
    line_cr_next    = line_cr;
    final_st_next   = final_st;
    emit            = 1'b0;
    done            = 1'b0;

    case (phase)
      hcbd_pkg::PH_WS, hcbd_pkg::PH_ZERO, hcbd_pkg::PH_HEX, hcbd_pkg::PH_TAIL: begin
        if (line_cr) begin
          line_cr_next = 1'b0;
          if (c == hcbd_pkg::CH_LF) begin
            done = 1'b1;
            if (!digit_seen) begin
              phase_next    = hcbd_pkg::PH_STOP;
              final_st_next = hcbd_pkg::ST_BAD;
            end else if (size_accum == '0) begin
              phase_next    = hcbd_pkg::PH_STOP;
              final_st_next = hcbd_pkg::ST_OK;
            end else begin
              bytes_left_next = size_accum;
              size_accum_next = '0;
              digit_seen_next = 1'b0;
              phase_next      = hcbd_pkg::PH_DATA;
            end
          end else if (phase == hcbd_pkg::PH_ZERO || phase == hcbd_pkg::PH_HEX) begin
            phase_next = hcbd_pkg::PH_TAIL;
          end
        end
        if (!done) begin
          if (c == hcbd_pkg::CH_CR) begin
            line_cr_next = 1'b1;
          end else begin
            case (phase_next)
              hcbd_pkg::PH_WS: begin
                if (!hcbd_pkg::is_space(c)) begin
                  if (dig.ok) begin
                    digit_seen_next = 1'b1;
                    size_accum_next = SIZE_BITS'(dig.value);
                    phase_next      = (dig.value == 4'd0) ? hcbd_pkg::PH_ZERO
                                                          : hcbd_pkg::PH_HEX;
                  end else begin
                    phase_next = hcbd_pkg::PH_TAIL;
                  end
                end
              end
              hcbd_pkg::PH_ZERO: begin
                if (c == 8'h78 || c == 8'h58) begin
                  phase_next = hcbd_pkg::PH_HEX;
                end else if (dig.ok) begin
                  size_accum_next = SIZE_BITS'(dig.value);
                  phase_next      = hcbd_pkg::PH_HEX;
                end else begin
                  phase_next = hcbd_pkg::PH_TAIL;
                end
              end
              hcbd_pkg::PH_HEX: begin
                if (dig.ok) begin
                  // top nibble in use means the next shift would lose bits
                  if (size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                    phase_next    = hcbd_pkg::PH_STOP;
                    final_st_next = hcbd_pkg::ST_OVF;
                  end else begin
                    size_accum_next = {size_accum[SIZE_BITS-5:0], dig.value};
                    digit_seen_next = 1'b1;
                  end
                end else begin
                  phase_next = hcbd_pkg::PH_TAIL;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        logic [SIZE_BITS-1:0] left;
        emit = 1'b1;
        left = bytes_left;
        if (left != '0) left = left - SIZE_BITS'(1);
        bytes_left_next = left;
        if (left == '0) begin
          skip_left_next = 2'd2;
          phase_next     = hcbd_pkg::PH_SKIP;
        end
      end
      hcbd_pkg::PH_SKIP: begin
        logic [1:0] sk;
        sk = skip_left;
        if (sk != 2'd0) sk = sk - 2'd1;
        skip_left_next = sk;
        if (sk == 2'd0) begin
          phase_next      = hcbd_pkg::PH_WS;
          size_accum_next = '0;
          digit_seen_next = 1'b0;
          line_cr_next    = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (body.is_last && phase_next != hcbd_pkg::PH_STOP) begin
      phase_next    = hcbd_pkg::PH_STOP;
      final_st_next = hcbd_pkg::ST_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= hcbd_pkg::PH_WS;
      size_accum <= '0;
      bytes_left <= '0;
      digit_seen <= 1'b0;
      skip_left  <= 2'd0;
      line_cr    <= 1'b0;
      final_st   <= hcbd_pkg::ST_RUN;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        size_accum <= size_accum_next;
        bytes_left <= bytes_left_next;
        digit_seen <= digit_seen_next;
        skip_left  <= skip_left_next;
        line_cr    <= line_cr_next;
        final_st   <= final_st_next;
        out_valid  <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte   <= emit ? c : 8'd0;
      byte_valid <= emit;
      status     <= (phase_next == hcbd_pkg::PH_STOP) ? final_st_next : hcbd_pkg::ST_RUN;
    end
  end

  assign result.valid      = out_valid;
  assign result.out_byte   = out_byte;
  assign result.byte_valid = byte_valid;
  assign result.status     = status;

  `HCBD_ASSERT(a_stop_sticks, clk, rst, phase == hcbd_pkg::PH_STOP |=> phase == hcbd_pkg::PH_STOP, "decoder left the stopped phase without reset")
  `HCBD_ASSERT(a_data_count, clk, rst, phase == hcbd_pkg::PH_DATA |-> bytes_left != '0, "data phase with no bytes left")
  `HCBD_ASSERT(a_skip_count, clk, rst, phase == hcbd_pkg::PH_SKIP |-> skip_left != 2'd0, "skip phase with nothing to skip")
  `HCBD_ASSERT(a_payload_status, clk, rst, out_valid && byte_valid |-> status == hcbd_pkg::ST_RUN || status == hcbd_pkg::ST_TRUNC, "payload word with a final status other than truncated")
  `HCBD_ASSERT_RST(a_reset_state, clk, rst |=> !out_valid && phase == hcbd_pkg::PH_WS, "reset did not clear the decoder")

endmodule

>>> test/chunked_decode_checker.sv
// ----------------------------------------------------------------------------
// chunked_decode_checker
// Watches the body and result channels of the chunked body decoder, decodes
// each accepted body word itself and compares every result word against the
// oldest word still due.
// ----------------------------------------------------------------------------
module chunked_decode_checker (
  input  logic   clk,
  input  logic   rst,
  hcbd_body_if   body,
  hcbd_result_if result,
  output int     mismatches,
  output int     words_due
);
  import hcbd_pkg::*;

  localparam int SIZE_BITS = SIZE_BITS_DEFAULT;
  localparam logic [SIZE_BITS-1:0] SIZE_ALL_ONES = '1;
  localparam logic [1:0] TRAILER_BYTES = 2'd2;
  localparam int REPORT_LIMIT = 10;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
  } decoded_word_t;

  phase_t                 phase;
  logic [SIZE_BITS-1:0]   size_acc;
  logic [SIZE_BITS-1:0]   chunk_left;
  logic                   digit_seen;
  logic [1:0]             skip_left;
  logic                   cr_pending;
  logic [2:0]             final_code;
  decoded_word_t          due_words[$];
  int                     errors;

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == " " || c == "\t" || c == CH_LF || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic void halt_decode(logic [2:0] code);
    phase = PH_STOP;
    final_code = code;
  endfunction

  function automatic void open_line();
    phase = PH_WS;
    size_acc = '0;
    digit_seen = 1'b0;
    cr_pending = 1'b0;
  endfunction

  function automatic void close_line();
    cr_pending = 1'b0;
    if (!digit_seen) begin
      halt_decode(ST_BAD);
    end else if (size_acc == 0) begin
      halt_decode(ST_OK);
    end else begin
      chunk_left = size_acc;
      size_acc = '0;
      digit_seen = 1'b0;
      phase = PH_DATA;
    end
  endfunction

  function automatic void size_line_byte(logic [7:0] c);
    int d;
    d = nibble_of(c);
    // CR only ends the line when LF follows straight away
    if (cr_pending) begin
      cr_pending = 1'b0;
      if (c == CH_LF) begin
        close_line();
        return;
      end
      if (phase == PH_ZERO || phase == PH_HEX) phase = PH_TAIL;
    end
    if (c == CH_CR) begin
      cr_pending = 1'b1;
      return;
    end
    case (phase)
      PH_WS: begin
        if (!is_blank(c)) begin
          if (d == 0) begin
            digit_seen = 1'b1;
            size_acc = '0;
            phase = PH_ZERO;
          end else if (d > 0) begin
            digit_seen = 1'b1;
            size_acc = SIZE_BITS'(d);
            phase = PH_HEX;
          end else begin
            phase = PH_TAIL;
          end
        end
      end
      PH_ZERO: begin
        if (c == "x" || c == "X") begin
          phase = PH_HEX;
        end else if (d >= 0) begin
          size_acc = SIZE_BITS'(d);
          phase = PH_HEX;
        end else begin
          phase = PH_TAIL;
        end
      end
      PH_HEX: begin
        if (d >= 0) begin
          if (size_acc > (SIZE_ALL_ONES >> 4)) begin
            halt_decode(ST_OVF);
            return;
          end
          size_acc = {size_acc[SIZE_BITS-5:0], 4'(d)};
          digit_seen = 1'b1;
        end else begin
          phase = PH_TAIL;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic decoded_word_t decode_byte(logic [7:0] c, logic last);
    decoded_word_t r;
    logic          emit;
    emit = 1'b0;
    case (phase)
      PH_WS, PH_ZERO, PH_HEX, PH_TAIL: size_line_byte(c);
      PH_DATA: begin
        emit = 1'b1;
        if (chunk_left != 0) chunk_left = chunk_left - SIZE_BITS'(1);
        if (chunk_left == 0) begin
          skip_left = TRAILER_BYTES;
          phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - 2'd1;
        if (skip_left == 0) open_line();
      end
      default: ;
    endcase
    // a data byte on the last word still goes out, in the word that carries the truncation
    if (last && phase != PH_STOP) halt_decode(ST_TRUNC);
    r.out_byte = emit ? c : 8'h00;
    r.byte_valid = emit;
    r.status = (phase == PH_STOP) ? final_code : ST_RUN;
    return r;
  endfunction

  function automatic void flag_word(string what, decoded_word_t want, decoded_word_t got);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("%0t: %s: expected byte %02h valid %0b status %0d, %s %02h valid %0b status %0d",
               $time, what, want.out_byte, want.byte_valid, want.status,
               "got byte", got.out_byte, got.byte_valid, got.status);
  endfunction

  always @(posedge clk) begin
    decoded_word_t want;
    decoded_word_t got;
    if (rst) begin
      open_line();
      chunk_left = '0;
      skip_left = '0;
      final_code = ST_RUN;
      due_words.delete();
      errors = 0;
    end else begin
      if (result.valid && result.ready) begin
        got.out_byte = result.out_byte;
        got.byte_valid = result.byte_valid;
        got.status = result.status;
        if (due_words.size() == 0) begin
          flag_word("result word with nothing due", '0, got);
        end else begin
          want = due_words.pop_front();
          if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
              got.status !== want.status)
            flag_word("result word mismatch", want, got);
        end
      end
      if (body.valid && body.ready)
        due_words.push_back(decode_byte(body.body_byte, body.is_last));
    end
    mismatches <= errors;
    words_due <= due_words.size();
  end

endmodule

>>> test/http_chunked_body_decoder_tb.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_tb
// Feeds one chunked body through the decoder: a directed opening of blanks,
// prefixes and line-end corner cases, then random chunks, then one randomly
// chosen way of ending (orderly, malformed line, size overflow or early end).
// Both sides stall at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 48;
  localparam int DRAIN_CYCLES = 8;
  localparam int BODY_TARGET  = 380;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } body_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  int         mismatches;
  int         words_due;
  int         rx_idle_pct = 0;
  int         hold_asked = 0;
  int         hold_served = 0;
  body_word_t stream[$];

  hcbd_body_if   body ();
  hcbd_result_if result ();

  http_chunked_body_decoder dut (
    .clk(clk),
    .rst(rst),
    .body(body),
    .result(result)
  );

  chunked_decode_checker decode_check (
    .clk(clk),
    .rst(rst),
    .body(body),
    .result(result),
    .mismatches(mismatches),
    .words_due(words_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void put(logic [7:0] value, logic last = 1'b0);
    body_word_t w;
    w.value = value;
    w.last = last;
    stream.push_back(w);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return "0" + 8'(n);
    return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  // blanks before the digits; a CR is never followed by LF here
  function automatic void put_blanks();
    logic [7:0] ws;
    logic [7:0] prev;
    int         k;
    prev = 8'h00;
    k = $urandom_range(3);
    for (int j = 0; j < k; j++) begin
      case ($urandom_range(5))
        0: ws = " ";
        1: ws = "\t";
        2: ws = 8'h0B;
        3: ws = 8'h0C;
        4: ws = CH_LF;
        default: ws = CH_CR;
      endcase
      if (prev == CH_CR && ws == CH_LF) ws = " ";
      put(ws);
      prev = ws;
    end
  endfunction

  function automatic void put_size_line(logic [31:0] size, logic last_on_lf);
    int         ndig;
    logic       prefixed;
    logic [7:0] ch;
    put_blanks();
    prefixed = ($urandom_range(3) == 0);
    if (prefixed) begin
      put("0");
      put($urandom_range(1) ? "x" : "X");
    end
    repeat ($urandom_range(2)) put("0");
    ndig = 1;
    while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
    // bare "0x" stands for a size of zero
    if (!(prefixed && size == 0 && $urandom_range(1) == 1))
      for (int j = ndig - 1; j >= 0; j--) put(hex_char(size[4 * j +: 4]));
    case ($urandom_range(3))
      0: begin
        put($urandom_range(1) ? ";" : " ");
        repeat ($urandom_range(4)) begin
          ch = 8'($urandom_range(255));
          put(ch == CH_CR ? ";" : ch);
        end
      end
      1: begin
        put(CH_CR);
        put(";");
      end
      default: ;
    endcase
    put(CH_CR);
    put(CH_LF, last_on_lf);
  endfunction

  initial begin : receiver
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_served + 1;
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((body.valid && body.ready) || (result.valid && result.ready)) quiet = 0;
      else quiet++;
    end
    $display("http_chunked_body_decoder_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int          n;
    int          k;
    int          gap_pct;
    int          hold_at;
    int          pause_at;
    logic [31:0] chunk_len;
    logic [7:0]  junk;

    body.valid <= 1'b0;
    body.body_byte <= 8'h00;
    body.is_last <= 1'b0;

    // opening: every blank, upper-case prefix, data extremes,
    // then a lone CR in the middle of a size line
    put(" "); put("\t"); put(8'h0B); put(8'h0C); put(CH_LF); put(CH_CR);
    put("0"); put("X"); put("3"); put(CH_CR); put(CH_LF);
    put(8'h00); put(8'hFF); put(8'h80); put(CH_CR); put(CH_LF);
    put("0"); put("1"); put(CH_CR); put(";"); put(CH_CR); put(CH_LF);
    put(8'h7F); put("Z"); put("Z");

    while (stream.size() < BODY_TARGET) begin
      chunk_len = ($urandom_range(6) != 0) ? $urandom_range(1, 16) : $urandom_range(17, 48);
      put_size_line(chunk_len, 1'b0);
      repeat (chunk_len) put(8'($urandom_range(255)));
      if ($urandom_range(4) != 0) begin
        put(CH_CR);
        put(CH_LF);
      end else begin
        repeat (2) put(8'($urandom_range(255)));
      end
    end

    case ($urandom_range(4))
      0: put_size_line(32'd0, 1'b1);
      1: begin
        // malformed: nothing but blanks, or text before any digit
        put_blanks();
        if ($urandom_range(2) != 0) begin
          case ($urandom_range(3))
            0: junk = "-";
            1: junk = "+";
            2: junk = "G";
            default: junk = "x";
          endcase
          put(junk);
          if ($urandom_range(1)) put("7");
        end
        put(CH_CR);
        put(CH_LF);
      end
      2: begin
        // nine significant digits cannot fit
        put_blanks();
        if ($urandom_range(1)) begin
          put("0");
          put("x");
        end
        put(hex_char(4'($urandom_range(1, 15))));
        repeat (8) put(hex_char(4'($urandom_range(15))));
      end
      3: begin
        // body cut off inside a (possibly huge) chunk
        chunk_len = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom();
        if (chunk_len == 0) chunk_len = 32'd1;
        put_size_line(chunk_len, 1'b0);
        k = $urandom_range(1, 5);
        for (int j = 0; j < k; j++) put(8'($urandom_range(255)), 1'(j == k - 1));
      end
      default: begin
        if ($urandom_range(1)) begin
          stream[$].last = 1'b1;
        end else begin
          put_blanks();
          put("a", 1'b1);
        end
      end
    endcase
    repeat ($urandom_range(3, 8)) put(8'($urandom_range(255)), 1'($urandom_range(1)));

    n = stream.size();
    pause_at = n / 2;
    hold_at = (2 * n) / 3 + 20;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < n; i++) begin
      gap_pct = (i < n / 3) ? 35 : (i < (2 * n) / 3) ? 84 : 0;
      rx_idle_pct <= (i < n / 3) ? 84 : (i < (2 * n) / 3) ? 35 : 0;
      if (i == hold_at) hold_asked <= hold_asked + 1;
      if (i == pause_at) begin
        body.valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
      end
      while ($urandom_range(99) < gap_pct) begin
        body.valid <= 1'b0;
        @(posedge clk);
      end
      body.valid <= 1'b1;
      body.body_byte <= stream[i].value;
      body.is_last <= stream[i].last;
      @(posedge clk);
      while (!body.ready) @(posedge clk);
    end
    body.valid <= 1'b0;

    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("http_chunked_body_decoder_tb: clean");
    end else begin
      $display("http_chunked_body_decoder_tb: errors");
    end
    $finish;
  end

endmodule
